/* rtl/ssvg_pkg.sv */
// Shared constants, types and register codes for the sphere strip vertex generator.
package ssvg_pkg;

  localparam int unsigned MAX_RINGS    = 256;
  localparam int unsigned MAX_SEGMENTS = 256;

  localparam int CNT_W   = 9;
  localparam int DEN_W   = 10;
  localparam int REM_W   = 9;
  localparam int NUM_W   = 28;
  localparam int PH_W    = 16;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 3;

  localparam int DIV_STEPS  = 7;
  localparam int DIV_LAT    = 4;
  localparam int SC_LAT     = 10;
  localparam int CRD_LAT    = 3;
  localparam int PIPE_LAT   = DIV_LAT + SC_LAT + CRD_LAT;

  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // ceil(2^(30+l)/d) with l = ceil(log2 d): exact floor division of any 30-bit value
  localparam logic [31:0] RECIP_42 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [31:0] RECIP_56 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [31:0] RECIP_20 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [31:0] RECIP_30 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [31:0] RECIP_6  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam logic [31:0] RECIP_12 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);

  typedef enum logic [INDEX_W-1:0] {
    REG_RADIUS_X      = 3'd0,
    REG_RADIUS_Y      = 3'd1,
    REG_RADIUS_Z      = 3'd2,
    REG_OFFSET_X      = 3'd3,
    REG_OFFSET_Y      = 3'd4,
    REG_OFFSET_Z      = 3'd5,
    REG_RING_COUNT    = 3'd6,
    REG_SEGMENT_COUNT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] ring_index;
    logic [8:0] segment_index;
  } grid_item_t;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               pair_last;
  } vertex_item_t;

  typedef struct packed {
    logic signed [31:0] radius_x;
    logic signed [31:0] radius_y;
    logic signed [31:0] radius_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } shape_cfg_t;

endpackage

/* rtl/ssvg_stream_if.sv */
// Valid/ready stream channel carrying one payload per request.
interface ssvg_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/ssvg_phase_div.sv */
// Pipelined restoring divider giving the 16-bit turn phase of num / den.
module ssvg_phase_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ssvg_pkg::NUM_W-1:0]    num,
  input  logic [ssvg_pkg::DEN_W-1:0]    den,
  output logic [ssvg_pkg::PH_W-1:0]     phase
);

  localparam int NW = ssvg_pkg::NUM_W;
  localparam int DW = ssvg_pkg::DEN_W;
  localparam int RW = ssvg_pkg::REM_W;
  localparam int NS = ssvg_pkg::DIV_LAT;

  logic [RW-1:0] rem_q [NS];
  logic [NW-1:0] x_q   [NS];
  logic [DW-1:0] den_q [NS];

  logic [RW-1:0] rem_d [NS];
  logic [NW-1:0] x_d   [NS];

  // x shifts the dividend out at the top and the quotient in at the bottom
  always_comb begin
    logic [RW-1:0] r;
    logic [NW-1:0] x;
    logic [DW-1:0] d;
    logic [RW:0]   t;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        r = '0;
        x = num;
        d = den;
      end else begin
        r = rem_q[s-1];
        x = x_q[s-1];
        d = den_q[s-1];
      end
      for (int i = 0; i < ssvg_pkg::DIV_STEPS; i++) begin
        t = {r, x[NW-1]};
        x = {x[NW-2:0], 1'b0};
        if (t >= (RW+1)'(d)) begin
          r    = RW'(t - (RW+1)'(d));
          x[0] = 1'b1;
        end else begin
          r = t[RW-1:0];
        end
      end
      rem_d[s] = r;
      x_d[s]   = x;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        rem_q[s] <= rem_d[s];
        x_q[s]   <= x_d[s];
        den_q[s] <= (s == 0) ? den : den_q[s-1];
      end
    end
  end

  assign phase = x_q[NS-1][ssvg_pkg::PH_W-1:0];

endmodule

/* rtl/ssvg_sincos.sv */
// Pipelined octant-folded Taylor sine and cosine of a 16-bit phase, Q1.15 out.
module ssvg_sincos (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ssvg_pkg::PH_W-1:0] phase,
  output logic signed [15:0]        sin_v,
  output logic signed [15:0]        cos_v
);

  localparam logic [30:0] ONE = ssvg_pkg::ONE_Q30;

  function automatic logic signed [15:0] to_q15(input logic [30:0] v);
    logic [31:0] r;
    r = (32'(v) + 32'd16384) >> 15;
    return (r > 32'd32767) ? 16'sd32767 : 16'(r);
  endfunction

  logic [2:0]  oct_q [9];
  logic [13:0] a;

  logic [45:0] p0;
  logic [29:0] x1;
  logic [59:0] sq1;
  logic [29:0] x2, y2, x3, y3, x4, y4, x5, y5, x6, y6;
  logic [61:0] ps2, pc2, ps4, pc4, ps6, pc6;
  logic [60:0] ps3, pc3, ps5, pc5, ps7, pc7;
  logic signed [15:0] s8, c8;

  logic [30:0] ts3, tc3, ts5, tc5, ts7, tc7, tc8;
  logic signed [15:0] sq, cq;

  // fold onto [0, pi/4]
  assign a = phase[13] ? (14'h2000 - {1'b0, phase[12:0]}) : {1'b0, phase[12:0]};

  assign ts3 = ONE - 31'(ps2 >> 36);
  assign tc3 = ONE - 31'(pc2 >> 36);
  assign ts5 = ONE - 31'(ps4 >> 35);
  assign tc5 = ONE - 31'(pc4 >> 35);
  assign ts7 = ONE - 31'(ps6 >> 33);
  assign tc7 = ONE - 31'(pc6 >> 34);
  assign tc8 = ONE - 31'(pc7 >> 31);

  always_ff @(posedge clk) begin
    if (en) begin
      oct_q[0] <= phase[15:13];
      for (int i = 1; i < 9; i++) oct_q[i] <= oct_q[i-1];

      p0  <= 46'(a) * 46'(ssvg_pkg::PI_Q30);

      x1  <= p0[44:15];
      sq1 <= 60'(p0[44:15]) * 60'(p0[44:15]);

      x2  <= x1;
      y2  <= sq1[59:30];
      ps2 <= 62'(sq1[59:30]) * 62'(ssvg_pkg::RECIP_42);
      pc2 <= 62'(sq1[59:30]) * 62'(ssvg_pkg::RECIP_56);

      x3  <= x2;
      y3  <= y2;
      ps3 <= 61'(y2) * 61'(ts3);
      pc3 <= 61'(y2) * 61'(tc3);

      x4  <= x3;
      y4  <= y3;
      ps4 <= 62'(ps3[59:30]) * 62'(ssvg_pkg::RECIP_20);
      pc4 <= 62'(pc3[59:30]) * 62'(ssvg_pkg::RECIP_30);

      x5  <= x4;
      y5  <= y4;
      ps5 <= 61'(y4) * 61'(ts5);
      pc5 <= 61'(y4) * 61'(tc5);

      x6  <= x5;
      y6  <= y5;
      ps6 <= 62'(ps5[59:30]) * 62'(ssvg_pkg::RECIP_6);
      pc6 <= 62'(pc5[59:30]) * 62'(ssvg_pkg::RECIP_12);

      ps7 <= 61'(x6) * 61'(ts7);
      pc7 <= 61'(y6) * 61'(tc7);

      s8 <= to_q15(31'(ps7 >> 30));
      c8 <= to_q15(tc8);

      case (oct_q[8][2:1])
        2'd0: begin sin_v <= sq;  cos_v <= cq;  end
        2'd1: begin sin_v <= cq;  cos_v <= -sq; end
        2'd2: begin sin_v <= -sq; cos_v <= -cq; end
        default: begin sin_v <= -cq; cos_v <= sq; end
      endcase
    end
  end

  // odd octants swap sine and cosine
  assign sq = oct_q[8][0] ? c8 : s8;
  assign cq = oct_q[8][0] ? s8 : c8;

endmodule

/* rtl/ssvg_coord.sv */
// Scale, round, offset and saturate of the three vertex coordinates.
module ssvg_coord (
  input  logic                   clk,
  input  logic                   en,
  input  ssvg_pkg::shape_cfg_t   cfg,
  input  logic signed [15:0]     sin_lat,
  input  logic signed [15:0]     cos_lat,
  input  logic signed [15:0]     sin_lon,
  input  logic signed [15:0]     cos_lon,
  output logic signed [31:0]     vert_x,
  output logic signed [31:0]     vert_y,
  output logic signed [31:0]     vert_z
);

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -35'sd2147483648) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  logic signed [31:0] cx0, cz0;
  logic signed [15:0] cy0;
  logic signed [63:0] px1, pz1;
  logic signed [47:0] py1;
  logic signed [63:0] rx, rz;
  logic signed [47:0] ry;

  // round half up then floor: an arithmetic shift does both signs
  assign rx = px1 + 64'sd536870912;
  assign rz = pz1 + 64'sd536870912;
  assign ry = py1 + 48'sd16384;

  always_ff @(posedge clk) begin
    if (en) begin
      cx0 <= 32'(sin_lat) * 32'(sin_lon);
      cz0 <= 32'(sin_lat) * 32'(cos_lon);
      cy0 <= cos_lat;

      px1 <= 64'(cfg.radius_x) * 64'(cx0);
      pz1 <= 64'(cfg.radius_z) * 64'(cz0);
      py1 <= 48'(cfg.radius_y) * 48'(cy0);

      vert_x <= sat32(35'($signed(rx[63:30])) + 35'(cfg.offset_x));
      vert_z <= sat32(35'($signed(rz[63:30])) + 35'(cfg.offset_z));
      vert_y <= sat32(35'($signed(ry[47:15])) + 35'(cfg.offset_y));
    end
  end

endmodule

/* rtl/sphere_strip_vertex_generator.sv */
// Sphere strip vertex generator: each accepted grid request (ring, segment) yields two
// vertices, first on latitude ring+1 then on latitude ring, the second marked pair_last.
// The input stage issues the two vertices one after the other into a pipeline that takes one
// vertex per clock while the output is not stalled, and it takes the next request as the
// second vertex of the held one issues. The whole pipeline holds while a vertex waits.
module sphere_strip_vertex_generator (
  input  logic                             clk,
  input  logic                             rst,
  ssvg_stream_if.sink                      item,
  ssvg_stream_if.source                    vertex,
  input  logic                             wr_en,
  input  logic [ssvg_pkg::INDEX_W-1:0]     wr_index,
  input  logic [ssvg_pkg::DATA_W-1:0]      wr_data
);

  localparam int LAT = ssvg_pkg::PIPE_LAT;
  localparam int CW  = ssvg_pkg::CNT_W;
  localparam int NW  = ssvg_pkg::NUM_W;
  localparam int DW  = ssvg_pkg::DEN_W;

  function automatic logic [CW-1:0] eff_count(input logic [CW-1:0] v,
                                              input logic [CW-1:0] lim);
    if (v == '0) return CW'(1);
    if (v > lim) return lim;
    return v;
  endfunction

  ssvg_pkg::shape_cfg_t cfg;
  logic [CW-1:0] ring_count;
  logic [CW-1:0] segment_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius_x  <= 32'sd65536;
      cfg.radius_y  <= 32'sd65536;
      cfg.radius_z  <= 32'sd65536;
      cfg.offset_x  <= '0;
      cfg.offset_y  <= '0;
      cfg.offset_z  <= '0;
      ring_count    <= CW'(16);
      segment_count <= CW'(32);
    end else if (wr_en) begin
      case (ssvg_pkg::reg_idx_t'(wr_index))
        ssvg_pkg::REG_RADIUS_X:      cfg.radius_x  <= wr_data;
        ssvg_pkg::REG_RADIUS_Y:      cfg.radius_y  <= wr_data;
        ssvg_pkg::REG_RADIUS_Z:      cfg.radius_z  <= wr_data;
        ssvg_pkg::REG_OFFSET_X:      cfg.offset_x  <= wr_data;
        ssvg_pkg::REG_OFFSET_Y:      cfg.offset_y  <= wr_data;
        ssvg_pkg::REG_OFFSET_Z:      cfg.offset_z  <= wr_data;
        ssvg_pkg::REG_RING_COUNT:    ring_count    <= wr_data[CW-1:0];
        ssvg_pkg::REG_SEGMENT_COUNT: segment_count <= wr_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // Input stage: hold one request and issue its two vertices on successive advances
  logic       pend;
  logic       half;
  logic [7:0] ring_h;
  logic [8:0] seg_h;
  logic       adv;
  logic       vld  [LAT];
  logic       last [LAT];

  assign adv        = !vld[LAT-1] || vertex.ready;
  assign item.ready = !pend || (half && adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      half <= 1'b0;
    end else if (item.valid && item.ready) begin
      pend <= 1'b1;
      half <= 1'b0;
    end else if (pend && adv) begin
      if (half) pend <= 1'b0;
      else      half <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      ring_h <= item.payload.ring_index;
      seg_h  <= item.payload.segment_index;
    end
  end

  logic [CW-1:0] rc, sc, ring_sel;
  logic [NW-1:0] lat_num, lon_num;
  logic [DW-1:0] lat_den, lon_den;

  assign rc       = eff_count(ring_count, CW'(ssvg_pkg::MAX_RINGS));
  assign sc       = eff_count(segment_count, CW'(ssvg_pkg::MAX_SEGMENTS));
  assign ring_sel = half ? CW'(ring_h) : CW'(ring_h) + CW'(1);
  assign lat_num  = NW'({ring_sel, 16'h0000}) + NW'(rc);
  assign lat_den  = DW'({rc, 1'b0});
  assign lon_num  = NW'({seg_h, 16'h0000}) + NW'(sc >> 1);
  assign lon_den  = DW'(sc);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= pend;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last[0] <= half;
      for (int i = 1; i < LAT; i++) last[i] <= last[i-1];
    end
  end

  logic [ssvg_pkg::PH_W-1:0] lat_phase, lon_phase;
  logic signed [15:0] sin_lat, cos_lat, sin_lon, cos_lon;
  logic signed [31:0] vx, vy, vz;

  ssvg_phase_div u_lat_div (
    .clk(clk), .en(adv), .num(lat_num), .den(lat_den), .phase(lat_phase)
  );

  ssvg_phase_div u_lon_div (
    .clk(clk), .en(adv), .num(lon_num), .den(lon_den), .phase(lon_phase)
  );

  ssvg_sincos u_lat_sc (
    .clk(clk), .en(adv), .phase(lat_phase), .sin_v(sin_lat), .cos_v(cos_lat)
  );

  ssvg_sincos u_lon_sc (
    .clk(clk), .en(adv), .phase(lon_phase), .sin_v(sin_lon), .cos_v(cos_lon)
  );

  ssvg_coord u_coord (
    .clk(clk), .en(adv), .cfg(cfg),
    .sin_lat(sin_lat), .cos_lat(cos_lat), .sin_lon(sin_lon), .cos_lon(cos_lon),
    .vert_x(vx), .vert_y(vy), .vert_z(vz)
  );

  assign vertex.valid             = vld[LAT-1];
  assign vertex.payload.vert_x    = vx;
  assign vertex.payload.vert_y    = vy;
  assign vertex.payload.vert_z    = vz;
  assign vertex.payload.pair_last = last[LAT-1];

endmodule
